// ===== design/utcc_pkg.sv =====
// ----------------------------------------------------------------------------
// utcc_pkg
// Shared types and constants for the seconds-to-calendar conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package utcc_pkg;

   // Number of register stages from the input channel to the result register.
   localparam int STAGE_COUNT = 8;

   // Field widths.
   localparam int TS_W     = 36;
   localparam int YEAR_W   = 13;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;

   // Internal widths.
   localparam int DAYS_W = 20;  // whole days since the epoch
   localparam int SECS_W = 17;  // seconds within a day
   localparam int Z_W    = 21;  // days since 0000-03-01
   localparam int ERA_W  = 4;   // 400-year eras
   localparam int DOE_W  = 18;  // day of era
   localparam int YOE_W  = 9;   // year of era
   localparam int DOY_W  = 9;   // day of March-based year
   localparam int REM_W  = 12;  // seconds within an hour
   localparam int MP_W   = 4;   // March-based month index

   // 86400 = 675 * 2^7, so days = (ts >> 7) / 675.
   localparam int DAY_SHIFT = 7;
   localparam logic [9:0]  DAY_ODD_FACTOR = 10'd675;
   localparam logic [29:0] RECIP_DAY      = 30'd814453058;  // ceil(2^39 / 675)
   localparam int RECIP_DAY_SHIFT = 39;

   localparam logic [Z_W-1:0]   MARCH_SHIFT      = 21'd719468;
   localparam logic [DOE_W-1:0] DAYS_PER_ERA     = 18'd146097;
   localparam logic [DOE_W-1:0] ERA_LAST_DAY     = 18'd146096;
   localparam logic [DOE_W-1:0] DAYS_PER_CENTURY = 18'd36524;
   localparam int ERA_COUNT         = 10;  // eras reachable from a 36-bit input
   localparam int CENTURIES_PER_ERA = 4;

   localparam logic [DOE_W-1:0]  DAYS_PER_YEAR     = 18'd365;
   localparam logic [18:0]       RECIP_YEAR        = 19'd367720;  // ceil(2^27 / 365)
   localparam int RECIP_YEAR_SHIFT = 27;
   localparam logic [YOE_W-1:0]  YEARS_PER_CENTURY = 9'd100;
   localparam logic [YEAR_W-1:0] YEARS_PER_ERA     = 13'd400;
   localparam int CENTURIES_PER_ERA_YEARS = 3;  // century marks inside one era

   localparam logic [SECS_W-1:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [17:0]       RECIP_HOUR    = 18'd149131;  // ceil(2^29 / 3600)
   localparam int RECIP_HOUR_SHIFT = 29;
   localparam logic [REM_W-1:0]  SECS_PER_MIN  = 12'd60;
   localparam logic [12:0]       RECIP_MIN     = 13'd4370;    // ceil(2^18 / 60)
   localparam int RECIP_MIN_SHIFT = 18;

   localparam int MONTHS_PER_YEAR = 12;
   localparam int JAN_INDEX       = 10;  // March-based index of January
   localparam int MARCH_MONTH     = 3;

   typedef struct packed {
      logic [STAGE_COUNT-1:0] load;  // stage register k takes new data
   } pipe_ctrl_type;

   // First day of each March-based month within the year.
   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
      logic [DOY_W-1:0] result;
      case (mp)
         4'd0:    result = 9'd0;
         4'd1:    result = 9'd31;
         4'd2:    result = 9'd61;
         4'd3:    result = 9'd92;
         4'd4:    result = 9'd122;
         4'd5:    result = 9'd153;
         4'd6:    result = 9'd184;
         4'd7:    result = 9'd214;
         4'd8:    result = 9'd245;
         4'd9:    result = 9'd275;
         4'd10:   result = 9'd306;
         4'd11:   result = 9'd337;
         default: result = 9'd0;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== design/utcc_req_if.sv =====
// ----------------------------------------------------------------------------
// utcc_req_if
// Input channel: one timestamp item per valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface utcc_req_if import utcc_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [TS_W-1:0] timestamp;

   modport source (output valid, output timestamp, input ready);
   modport sink   (input valid, input timestamp, output ready);
endinterface

`default_nettype wire

// ===== design/utcc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// utcc_rsp_if
// Result channel: one calendar date and time item per valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface utcc_rsp_if import utcc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [YEAR_W-1:0]   year;
   logic [MONTH_W-1:0]  month;
   logic [DAY_W-1:0]    day;
   logic [HOUR_W-1:0]   hour;
   logic [MINUTE_W-1:0] minute;
   logic [SECOND_W-1:0] second;

   modport source (output valid, output year, output month, output day,
                   output hour, output minute, output second, input ready);
   modport sink   (input valid, input year, input month, input day,
                   input hour, input minute, input second, output ready);
endinterface

`default_nettype wire

// ===== design/utcc_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// utcc_pipe_ctrl
// Valid bits and per-stage load enables for the conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module utcc_pipe_ctrl import utcc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   output logic         out_valid,
   input  wire logic    out_ready,
   output pipe_ctrl_type ctrl
);

   logic [STAGE_COUNT-1:0] valid_ff;
   logic [STAGE_COUNT-1:0] valid_in;
   logic [STAGE_COUNT-1:0] ready;
   logic [STAGE_COUNT-1:0] src_valid;

   // A stage can take data when it is empty or its contents move on.
   always_comb begin
      src_valid = {valid_ff[STAGE_COUNT-2:0], in_valid};
      ready[STAGE_COUNT-1] = !valid_ff[STAGE_COUNT-1] || out_ready;
      for (int k = STAGE_COUNT - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      for (int k = 0; k < STAGE_COUNT; k++) begin
         valid_in[k] = ready[k] ? src_valid[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load = ready & src_valid;
   assign in_ready  = ready[0];
   assign out_valid = valid_ff[STAGE_COUNT-1];

   a_full_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff && !out_ready) |-> !in_ready)
      else $error("input accepted while every stage is full and stalled");

   a_stalled_stage_keeps_item: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[0] && !ready[0]) |=> valid_ff[0])
      else $error("first stage dropped an item while stalled");

   a_result_held_until_taken: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid)
      else $error("result item dropped before it was taken");

endmodule

`default_nettype wire

// ===== design/utcc_day_split.sv =====
// ----------------------------------------------------------------------------
// utcc_day_split
// Splits the timestamp into whole days and seconds of the day, and shifts the
// day count to a March-based calendar origin.
// ----------------------------------------------------------------------------
`default_nettype none

module utcc_day_split import utcc_pkg::*; (
   input  wire logic            clock,
   input  wire pipe_ctrl_type   ctrl,
   input  wire logic [TS_W-1:0] timestamp,
   output logic [SECS_W-1:0]    secs,
   output logic [Z_W-1:0]       z
);

   logic [58:0]        day_prod;
   logic [DAYS_W-1:0]  days_in;
   logic [DAYS_W-1:0]  days_ff;
   logic [SECS_W-1:0]  ts_lo_ff;
   logic [9:0]         day_lo_prod;
   logic [SECS_W-1:0]  secs_in;
   logic [SECS_W-1:0]  secs_ff;
   logic [Z_W-1:0]     z_in;
   logic [Z_W-1:0]     z_ff;

   // Stage 1: exact reciprocal multiply for the divide by 675.
   assign day_prod = 59'(timestamp[TS_W-1:DAY_SHIFT]) * 59'(RECIP_DAY);
   assign days_in  = day_prod[RECIP_DAY_SHIFT +: DAYS_W];

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         days_ff  <= days_in;
         ts_lo_ff <= timestamp[SECS_W-1:0];
      end
   end

   // Stage 2: the remainder is below 2^17, so only the low bits are needed.
   assign day_lo_prod = days_ff[9:0] * DAY_ODD_FACTOR;
   assign secs_in     = ts_lo_ff - {day_lo_prod, {DAY_SHIFT{1'b0}}};
   assign z_in        = Z_W'(days_ff) + MARCH_SHIFT;

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         secs_ff <= secs_in;
         z_ff    <= z_in;
      end
   end

   assign secs = secs_ff;
   assign z    = z_ff;

endmodule

`default_nettype wire

// ===== design/utcc_tod.sv =====
// ----------------------------------------------------------------------------
// utcc_tod
// Time of day: hour, minute and second from the seconds within a day.
// ----------------------------------------------------------------------------
`default_nettype none

module utcc_tod import utcc_pkg::*; (
   input  wire logic              clock,
   input  wire pipe_ctrl_type     ctrl,
   input  wire logic [SECS_W-1:0] secs,
   output logic [HOUR_W-1:0]      hour,
   output logic [MINUTE_W-1:0]    minute,
   output logic [SECOND_W-1:0]    second
);

   logic [34:0]         hour_prod;
   logic [HOUR_W-1:0]   hour3_ff, hour4_ff, hour5_ff, hour6_ff, hour7_ff, hour8_ff;
   logic [SECS_W-1:0]   secs3_ff;
   logic [SECS_W-1:0]   hour_secs;
   logic [SECS_W-1:0]   rem_full;
   logic [REM_W-1:0]    rem4_ff, rem5_ff;
   logic [24:0]         min_prod;
   logic [MINUTE_W-1:0] minute5_ff, minute6_ff, minute7_ff, minute8_ff;
   logic [REM_W-1:0]    min_secs;
   logic [REM_W-1:0]    sec_full;
   logic [SECOND_W-1:0] second6_ff, second7_ff, second8_ff;

   // Stage 3: hour by reciprocal multiply.
   assign hour_prod = 35'(secs) * 35'(RECIP_HOUR);

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         hour3_ff <= hour_prod[RECIP_HOUR_SHIFT +: HOUR_W];
         secs3_ff <= secs;
      end
   end

   // Stage 4: seconds left within the hour.
   assign hour_secs = SECS_W'(hour3_ff) * SECS_PER_HOUR;
   assign rem_full  = secs3_ff - hour_secs;

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         rem4_ff  <= rem_full[REM_W-1:0];
         hour4_ff <= hour3_ff;
      end
   end

   // Stage 5: minute by reciprocal multiply.
   assign min_prod = 25'(rem4_ff) * 25'(RECIP_MIN);

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         minute5_ff <= min_prod[RECIP_MIN_SHIFT +: MINUTE_W];
         rem5_ff    <= rem4_ff;
         hour5_ff   <= hour4_ff;
      end
   end

   // Stage 6: second is what remains of the minute.
   assign min_secs = REM_W'(minute5_ff) * SECS_PER_MIN;
   assign sec_full = rem5_ff - min_secs;

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         second6_ff <= sec_full[SECOND_W-1:0];
         minute6_ff <= minute5_ff;
         hour6_ff   <= hour5_ff;
      end
   end

   // Stages 7 and 8 keep the time aligned with the date path.
   always_ff @(posedge clock) begin
      if (ctrl.load[6]) begin
         second7_ff <= second6_ff;
         minute7_ff <= minute6_ff;
         hour7_ff   <= hour6_ff;
      end
      if (ctrl.load[7]) begin
         second8_ff <= second7_ff;
         minute8_ff <= minute7_ff;
         hour8_ff   <= hour7_ff;
      end
   end

   assign hour   = hour8_ff;
   assign minute = minute8_ff;
   assign second = second8_ff;

endmodule

`default_nettype wire

// ===== design/utcc_civil.sv =====
// ----------------------------------------------------------------------------
// utcc_civil
// Civil date from a March-based day count: era, year of era, day of year,
// then month and day of month.
// ----------------------------------------------------------------------------
`default_nettype none

module utcc_civil import utcc_pkg::*; (
   input  wire logic           clock,
   input  wire pipe_ctrl_type  ctrl,
   input  wire logic [Z_W-1:0] z,
   output logic [YEAR_W-1:0]   year,
   output logic [MONTH_W-1:0]  month,
   output logic [DAY_W-1:0]    day
);

   logic [ERA_W-1:0]   era_in;
   logic [Z_W-1:0]     era_base;
   logic [Z_W-1:0]     doe_full;
   logic [ERA_W-1:0]   era3_ff, era4_ff, era5_ff, era6_ff;
   logic [DOE_W-1:0]   doe3_ff, doe4_ff, doe5_ff, doe6_ff;

   logic [34:0]        quad_prod;
   logic [2:0]         cent_in;
   logic [6:0]         quad4_ff;
   logic [2:0]         cent4_ff;
   logic               last4_ff;

   logic [DOE_W-1:0]   num_in;
   logic [DOE_W-1:0]   num5_ff;

   logic [36:0]        year_prod;
   logic [YOE_W-1:0]   yoe6_ff;

   logic [1:0]         cent_yoe;
   logic [DOE_W-1:0]   year_days;
   logic [DOE_W-1:0]   doy_full;
   logic [DOY_W-1:0]   doy7_ff;
   logic [YEAR_W-1:0]  ybase7_ff;

   logic [MP_W-1:0]    mp;
   logic [DOY_W-1:0]   dom_full;
   logic [MONTH_W-1:0] month_in;
   logic [YEAR_W-1:0]  year_in;
   logic [YEAR_W-1:0]  year8_ff;
   logic [MONTH_W-1:0] month8_ff;
   logic [DAY_W-1:0]   day8_ff;

   // Stage 3: era by comparison against each era boundary.
   always_comb begin
      era_in   = '0;
      era_base = '0;
      for (int k = 1; k <= ERA_COUNT; k++) begin
         if (z >= Z_W'(k) * Z_W'(DAYS_PER_ERA)) begin
            era_in   = ERA_W'(k);
            era_base = Z_W'(k) * Z_W'(DAYS_PER_ERA);
         end
      end
      doe_full = z - era_base;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         era3_ff <= era_in;
         doe3_ff <= doe_full[DOE_W-1:0];
      end
   end

   // Stage 4: leap-day corrections. doe/1460 is (doe/4)/365.
   assign quad_prod = 35'(doe3_ff[DOE_W-1:2]) * 35'(RECIP_YEAR);

   always_comb begin
      cent_in = '0;
      for (int k = 1; k <= CENTURIES_PER_ERA; k++) begin
         if (doe3_ff >= DOE_W'(k) * DAYS_PER_CENTURY) begin
            cent_in = 3'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         quad4_ff <= quad_prod[RECIP_YEAR_SHIFT +: 7];
         cent4_ff <= cent_in;
         last4_ff <= (doe3_ff == ERA_LAST_DAY);
         doe4_ff  <= doe3_ff;
         era4_ff  <= era3_ff;
      end
   end

   // Stage 5: day count with leap days removed.
   assign num_in = doe4_ff - DOE_W'(quad4_ff) + DOE_W'(cent4_ff) - DOE_W'(last4_ff);

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         num5_ff <= num_in;
         doe5_ff <= doe4_ff;
         era5_ff <= era4_ff;
      end
   end

   // Stage 6: year of era by reciprocal multiply.
   assign year_prod = 37'(num5_ff) * 37'(RECIP_YEAR);

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         yoe6_ff <= year_prod[RECIP_YEAR_SHIFT +: YOE_W];
         doe6_ff <= doe5_ff;
         era6_ff <= era5_ff;
      end
   end

   // Stage 7: day of year and the year without the January carry.
   always_comb begin
      cent_yoe = '0;
      for (int k = 1; k <= CENTURIES_PER_ERA_YEARS; k++) begin
         if (yoe6_ff >= YOE_W'(k) * YEARS_PER_CENTURY) begin
            cent_yoe = 2'(k);
         end
      end
      year_days = DOE_W'(yoe6_ff) * DAYS_PER_YEAR + DOE_W'(yoe6_ff[YOE_W-1:2])
                  - DOE_W'(cent_yoe);
      doy_full  = doe6_ff - year_days;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[6]) begin
         doy7_ff   <= doy_full[DOY_W-1:0];
         ybase7_ff <= YEAR_W'(yoe6_ff) + YEAR_W'(era6_ff) * YEARS_PER_ERA;
      end
   end

   // Stage 8: month by comparison with month starts; January and February
   // belong to the next civil year.
   always_comb begin
      mp = '0;
      for (int k = 1; k < MONTHS_PER_YEAR; k++) begin
         if (doy7_ff >= month_start(MP_W'(k))) begin
            mp = MP_W'(k);
         end
      end
      dom_full = doy7_ff - month_start(mp) + 9'd1;
      if (mp >= MP_W'(JAN_INDEX)) begin
         month_in = mp - MONTH_W'(JAN_INDEX - 1);
         year_in  = ybase7_ff + 13'd1;
      end else begin
         month_in = mp + MONTH_W'(MARCH_MONTH);
         year_in  = ybase7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[7]) begin
         year8_ff  <= year_in;
         month8_ff <= month_in;
         day8_ff   <= dom_full[DAY_W-1:0];
      end
   end

   assign year  = year8_ff;
   assign month = month8_ff;
   assign day   = day8_ff;

endmodule

`default_nettype wire

// ===== design/unix_time_to_calendar_unit.sv =====
// ----------------------------------------------------------------------------
// unix_time_to_calendar_unit
// Converts seconds since 1970-01-01 00:00:00 UTC into the Gregorian date and
// time of day through an eight-stage pipeline.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Item contents
//   req_ch    in         valid/ready    timestamp (36 bits, seconds)
//   rsp_ch    out        valid/ready    year, month, day, hour, minute, second
//
// The accepting edge loads the first of eight register stages, and the result
// is presented from the last stage. A new item may enter on every cycle while
// rsp_ch is ready, so the sustained rate is one item per cycle while rsp_ch is
// ready, since every stage passes its item on each cycle that the next stage
// can take it.
// Reset clears only the stage valid bits; data registers carry no reset.
// A stall on rsp_ch holds the last stage, and empty stages upstream keep
// filling, so items are accepted until every stage holds one.
// ----------------------------------------------------------------------------
`default_nettype none

module unix_time_to_calendar_unit import utcc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   utcc_req_if.sink   req_ch,
   utcc_rsp_if.source rsp_ch
);

   pipe_ctrl_type     ctrl;
   logic [SECS_W-1:0] secs;
   logic [Z_W-1:0]    z;

   // The control block owns all valid bits; datapath stages only see loads.
   utcc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .ctrl      (ctrl)
   );

   // Stages 1 and 2: days and seconds of the day.
   utcc_day_split u_day_split (
      .clock     (clock),
      .ctrl      (ctrl),
      .timestamp (req_ch.timestamp),
      .secs      (secs),
      .z         (z)
   );

   // Stages 3 to 8: time of day, padded to match the date path.
   utcc_tod u_tod (
      .clock  (clock),
      .ctrl   (ctrl),
      .secs   (secs),
      .hour   (rsp_ch.hour),
      .minute (rsp_ch.minute),
      .second (rsp_ch.second)
   );

   // Stages 3 to 8: era, year of era, day of year, month and day.
   utcc_civil u_civil (
      .clock (clock),
      .ctrl  (ctrl),
      .z     (z),
      .year  (rsp_ch.year),
      .month (rsp_ch.month),
      .day   (rsp_ch.day)
   );

   // A ready result side frees every stage, so the input must be ready too.
   a_ready_reaches_input: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.ready |-> req_ch.ready)
      else $error("result side ready but input side stalled");

   // Catches a wrong reciprocal or a misaligned stage in the date path.
   a_date_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.month >= 4'd1 && rsp_ch.month <= 4'd12 &&
                        rsp_ch.day >= 5'd1 && rsp_ch.year >= 13'd1970 &&
                        rsp_ch.year <= 13'd4147))
      else $error("date result out of range");

   a_time_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.hour <= 5'd23 && rsp_ch.minute <= 6'd59 &&
                        rsp_ch.second <= 6'd59))
      else $error("time-of-day result out of range");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the seconds-to-calendar conversion unit. Timestamps
// go in through the request channel. For each accepted timestamp, the bench
// computes the Gregorian date and time of day in its own civil-calendar
// arithmetic and queues it. Results leaving the response channel are checked
// in order against that queue. Both channels idle at random in changing
// patterns, and one long response stall fills the pipeline up to its input.
// ----------------------------------------------------------------------------

module tb_top import utcc_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // One calendar result, laid out like the response channel payload.
   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
   } calendar_type;

   // Calendar arithmetic constants. The day count is moved to an era-based
   // calendar whose years begin on March 1st, so that the leap day falls at
   // the very end of a year.
   localparam longint unsigned SECONDS_PER_DAY    = 86400;
   localparam longint unsigned SECONDS_PER_HOUR   = 3600;
   localparam longint unsigned SECONDS_PER_MINUTE = 60;
   localparam longint unsigned ERA_DAYS           = 146097;  // 400 Gregorian years
   localparam longint unsigned EPOCH_TO_MARCH_ZERO = 719468; // 1970-01-01 from 0000-03-01
   localparam int unsigned     FEBRUARY           = 2;
   localparam int unsigned     FIRST_YEAR         = 1970;
   localparam int unsigned     LAST_FULL_YEAR     = 4146;
   localparam longint unsigned LAST_FULL_DAY      = 795363;  // last whole day below 2^36 s

   // Stimulus and run control.
   localparam int unsigned RANDOM_ITEMS_PER_PHASE = 430;
   localparam int unsigned STALL_ITEMS            = 40;
   localparam int unsigned STALL_CYCLES           = 400;
   localparam int unsigned WATCHDOG_LIMIT         = 5000;
   localparam int unsigned REPORT_LIMIT           = 50;

   logic clock = 1'b0;
   logic reset = 1'b1;

   utcc_req_if req_ch ();
   utcc_rsp_if rsp_ch ();

   unix_time_to_calendar_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #2 clock = ~clock;

   // Dates still inside the pipeline, oldest first.
   calendar_type expected_dates[$];
   int unsigned  error_count = 0;

   // Chance in percent that a side idles for a cycle. The test tasks set these
   // per phase; the response side also takes a one-shot long hold request.
   int unsigned send_idle_pct    = 0;
   int unsigned recv_idle_pct    = 0;
   int unsigned rsp_hold_request = 0;
   int unsigned rsp_hold_left    = 0;
   int unsigned quiet_cycles     = 0;

   // -------------------------------------------------------------------------
   // Calendar arithmetic
   // -------------------------------------------------------------------------

   // Date and time of day for a count of seconds since the epoch. The year is
   // found from the day of its 400-year era. The era starts on March 1st, so
   // the century and 400-year leap corrections are plain divisions and the
   // leap day is simply the last day of the March-based year.
   function automatic calendar_type calendar_of_timestamp(input logic [TS_W-1:0] ts);
      longint unsigned day_count, sec_of_day, shifted, era, day_of_era;
      longint unsigned year_of_era, day_of_year, month_index, yr, mon, dy;
      calendar_type    date;
      day_count   = ts / SECONDS_PER_DAY;
      sec_of_day  = ts % SECONDS_PER_DAY;
      shifted     = day_count + EPOCH_TO_MARCH_ZERO;
      era         = shifted / ERA_DAYS;
      day_of_era  = shifted - era * ERA_DAYS;
      year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                     - day_of_era / 146096) / 365;
      day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
      month_index = (5 * day_of_year + 2) / 153;
      dy          = day_of_year - (153 * month_index + 2) / 5 + 1;
      mon         = (month_index < 10) ? month_index + 3 : month_index - 9;
      // January and February belong to the March-based year before.
      yr          = year_of_era + era * 400 + ((mon <= FEBRUARY) ? 1 : 0);
      date.year   = YEAR_W'(yr);
      date.month  = MONTH_W'(mon);
      date.day    = DAY_W'(dy);
      date.hour   = HOUR_W'(sec_of_day / SECONDS_PER_HOUR);
      date.minute = MINUTE_W'((sec_of_day % SECONDS_PER_HOUR) / SECONDS_PER_MINUTE);
      date.second = SECOND_W'(sec_of_day % SECONDS_PER_MINUTE);
      return date;
   endfunction

   // Days since the epoch for a civil date, used only to aim stimulus at
   // month, year and leap-day boundaries. Valid for years from 1970 on.
   function automatic longint unsigned epoch_day(input int unsigned yr,
                                                 input int unsigned mon,
                                                 input int unsigned dy);
      longint unsigned yr_adj, era, yoe, doy, mp;
      yr_adj = (mon <= FEBRUARY) ? yr - 1 : yr;
      era    = yr_adj / 400;
      yoe    = yr_adj - era * 400;
      mp     = (mon > FEBRUARY) ? mon - 3 : mon + 9;
      doy    = (153 * mp + 2) / 5 + dy - 1;
      return era * ERA_DAYS + yoe * 365 + yoe / 4 - yoe / 100 + doy - EPOCH_TO_MARCH_ZERO;
   endfunction

   function automatic logic [TS_W-1:0] timestamp_of(input int unsigned yr,
                                                    input int unsigned mon,
                                                    input int unsigned dy,
                                                    input int unsigned hr,
                                                    input int unsigned mi,
                                                    input int unsigned se);
      return TS_W'(epoch_day(yr, mon, dy) * SECONDS_PER_DAY
                   + hr * SECONDS_PER_HOUR + mi * SECONDS_PER_MINUTE + se);
   endfunction

   // A random timestamp. A third of them are spread over the whole 36-bit
   // range, a third sit on the first, last or a random second of a day around
   // the start of a random month, and a third land on minute and hour edges of a
   // random day.
   function automatic logic [TS_W-1:0] random_timestamp();
      longint unsigned day_count, sec_of_day;
      logic [TS_W-1:0] ts;
      case ($urandom_range(2))
         0: begin
            ts = {4'($urandom), 32'($urandom)};
         end
         1: begin
            day_count = epoch_day($urandom_range(LAST_FULL_YEAR, FIRST_YEAR),
                                  $urandom_range(12, 1), 1);
            // Step back onto the last day of the previous month half the time.
            if ($urandom_range(1) == 1 && day_count > 0)
               day_count = day_count - 1;
            case ($urandom_range(2))
               0:       sec_of_day = 0;
               1:       sec_of_day = SECONDS_PER_DAY - 1;
               default: sec_of_day = $urandom_range(SECONDS_PER_DAY - 1);
            endcase
            ts = TS_W'(day_count * SECONDS_PER_DAY + sec_of_day);
         end
         default: begin
            day_count  = {$urandom, $urandom} % (LAST_FULL_DAY + 1);
            sec_of_day = $urandom_range(23) * SECONDS_PER_HOUR;
            case ($urandom_range(2))
               0:       sec_of_day += 0;
               1:       sec_of_day += 59 * SECONDS_PER_MINUTE;
               default: sec_of_day += $urandom_range(59) * SECONDS_PER_MINUTE;
            endcase
            case ($urandom_range(2))
               0:       sec_of_day += 0;
               1:       sec_of_day += 59;
               default: sec_of_day += $urandom_range(59);
            endcase
            ts = TS_W'(day_count * SECONDS_PER_DAY + sec_of_day);
         end
      endcase
      return ts;
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Offers one timestamp and returns at the rising edge where it is taken.
   // Valid and the payload change only at falling edges. Random idle cycles
   // go in front of the item, and back-to-back items keep valid high.
   task automatic send_timestamp(input logic [TS_W-1:0] ts);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.timestamp <= ts;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      expected_dates.push_back(calendar_of_timestamp(ts));
   endtask

   // Takes valid down and waits until every queued date has come back. It then
   // waits on to catch any stray extra result.
   task automatic drain_pipeline();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_dates.size() != 0)
         @(posedge clock);
      repeat (STAGE_COUNT + 4) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Response side
   // -------------------------------------------------------------------------

   // Ready changes at falling edges. A pending hold request is taken over
   // here and counted down in this process; otherwise ready is dropped at
   // random with the current idle chance.
   always @(negedge clock) begin
      if (rsp_hold_request != 0) begin
         rsp_hold_left    = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left != 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Every item taken from the response channel is checked against the
   // oldest queued date. The reports are capped to keep the log readable,
   // but every mismatch still counts as an error.
   always @(posedge clock) begin
      calendar_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.year, rsp_ch.month, rsp_ch.day,
                 rsp_ch.hour, rsp_ch.minute, rsp_ch.second};
         if (expected_dates.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: result item with no timestamp pending: %0d-%0d-%0d %0d:%0d:%0d",
                        $time, got.year, got.month, got.day, got.hour, got.minute,
                        got.second);
         end else begin
            want = expected_dates.pop_front();
            if (got.year !== want.year || got.month !== want.month
                || got.day !== want.day || got.hour !== want.hour
                || got.minute !== want.minute || got.second !== want.second) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: expected %0d-%0d-%0d %0d:%0d:%0d, actual %0d-%0d-%0d %0d:%0d:%0d",
                           $time, want.year, want.month, want.day, want.hour,
                           want.minute, want.second, got.year, got.month, got.day,
                           got.hour, got.minute, got.second);
            end
         end
      end
   end

   // The watchdog counts cycles in which neither channel moves an item. The
   // longest legal quiet stretch is the deliberate response hold, far below
   // the limit.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Edges of the time of day, the first and last representable seconds,
   // the turn of the century, and the leap-year rule in all three forms: an
   // ordinary leap year, a century that is not a leap year, and a century
   // that is.
   task automatic test_calendar_edges();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_timestamp('0);
      send_timestamp(TS_W'(1));
      send_timestamp(TS_W'(59));
      send_timestamp(TS_W'(60));
      send_timestamp(TS_W'(3599));
      send_timestamp(TS_W'(3600));
      send_timestamp(TS_W'(86399));
      send_timestamp(TS_W'(86400));
      send_timestamp(timestamp_of(1972, 2, 28, 23, 59, 59));
      send_timestamp(timestamp_of(1972, 2, 29, 12, 0, 0));
      send_timestamp(timestamp_of(1972, 3, 1, 0, 0, 0));
      send_timestamp(timestamp_of(1999, 12, 31, 23, 59, 59));
      send_timestamp(timestamp_of(2000, 1, 1, 0, 0, 0));
      send_timestamp(timestamp_of(2000, 2, 29, 23, 59, 59));
      send_timestamp(timestamp_of(2000, 3, 1, 0, 0, 0));
      send_timestamp(TS_W'(32'h7FFF_FFFF));
      send_timestamp(TS_W'(32'hFFFF_FFFF));
      send_timestamp(timestamp_of(2100, 2, 28, 23, 59, 59));
      send_timestamp(timestamp_of(2100, 3, 1, 0, 0, 0));
      send_timestamp(timestamp_of(2400, 2, 29, 6, 30, 30));
      send_timestamp(timestamp_of(4147, 1, 1, 0, 0, 0));
      send_timestamp({TS_W{1'b1}});
      drain_pipeline();
   endtask

   // The response side holds ready low for a long stretch while the request
   // side keeps offering items, so the pipeline fills and stops taking input.
   task automatic test_full_pipeline_stall();
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      rsp_hold_request = STALL_CYCLES;
      repeat (STALL_ITEMS) send_timestamp(random_timestamp());
      drain_pipeline();
   endtask

   // Random timestamps under one pattern of idle cycles on both sides.
   task automatic test_random_dates(input int unsigned send_idle,
                                    input int unsigned recv_idle);
      send_idle_pct = send_idle;
      recv_idle_pct = recv_idle;
      repeat (RANDOM_ITEMS_PER_PHASE) send_timestamp(random_timestamp());
      drain_pipeline();
   endtask

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.timestamp = '0;
      rsp_ch.ready     = 1'b0;

      // Reset is released at a falling edge.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_calendar_edges();
      test_full_pipeline_stall();
      test_random_dates(20, 59);
      test_random_dates(59, 20);
      test_random_dates(0, 0);

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
